// ===== rtl/core/scfr_pkg.sv =====
// package for the serial command frame receiver
// holds header codes, limits, state encoding and the result beat layout
// no dependencies
package scfr_pkg;

  localparam int RX_BYTE_W  = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic [7:0] HDR_A = 8'hAA;
  localparam logic [7:0] HDR_B = 8'hBB;
  localparam logic [7:0] HDR_C = 8'hCC;

  localparam logic [8:0] PAYLOAD_BYTES = 9'd3;
  localparam logic [7:0] RAW_CAPACITY  = 8'd128;

  localparam logic [8:0] TEMP_OFFSET = 9'd15;
  localparam logic [7:0] TEMP_MIN    = 8'd2;
  localparam logic [7:0] WIND_LIMIT  = 8'd5;
  localparam logic [7:0] MODE_LIMIT  = 8'd4;

  typedef enum logic [1:0] {
    HUNT_A   = 2'd0,
    EXPECT_B = 2'd1,
    EXPECT_C = 2'd2,
    PAYLOAD  = 2'd3
  } hdr_state_t;

  typedef struct packed {
    logic       raw_full;
    logic [7:0] raw_byte;
    logic [6:0] raw_index;
    logic       raw_valid;
    logic [1:0] op_mode;
    logic       mode_valid;
    logic [2:0] wind_speed;
    logic       wind_valid;
    logic [8:0] temperature;
    logic       temp_valid;
    logic       in_frame;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ===== rtl/core/serial_command_frame_receiver.sv =====
// serial command frame receiver top level
// per-beat header hunt, payload capture and raw capture, with output skid stage
// depends on scfr_pkg
//
// usage:
//   s_* channel takes one received byte per beat: tdata = rx_byte, tuser = rx_error.
//   errored bytes change no state and give a beat in which only in_frame may be set.
//   m_* channel gives exactly one result beat per input beat, in order.
//   cfg_* channel writes raw_capture (1 raw capture, 0 frame parsing) and clears
//   the byte count; write it only while no beat is in flight. cfg_ready is
//   always high.
//   results: each result is computed combinationally from the beat and the state
//   registers and is registered in the result register, or in the skid register
//   while the output stalls; throughput: one beat per cycle while m_tready is high.
//   stalls: when m_tready is low the result register holds, one more beat is
//   taken into a skid register, then s_tready drops until the output drains.
//   reset: rst (synchronous, active high) clears the mode, header state,
//   byte count, frame flag and both valid flags; payload bytes are not reset.
module serial_command_frame_receiver (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [scfr_pkg::RX_BYTE_W-1:0]       s_tdata,  // rx_byte
  input  logic                                 s_tuser,  // rx_error
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // in_frame, temp_valid, temperature[8:0], wind_valid, wind_speed[2:0],
  // mode_valid, op_mode[1:0], raw_valid, raw_index[6:0], raw_byte[7:0],
  // raw_full, zero fill
  output logic [scfr_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_data   // raw_capture
);
  import scfr_pkg::*;

  logic       raw_capture;
  hdr_state_t header_state, header_state_next;
  logic [7:0] byte_count, byte_count_next;
  logic       frame_flag, frame_flag_next;
  logic [7:0] payload_store [2];
  logic       store_en;

  result_t    res_next;
  result_t    out_res;
  result_t    skid_res;
  logic       skid_valid;
  logic       accept;
  logic       out_free;
  logic [8:0] count_inc;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign count_inc = {1'b0, byte_count} + 9'd1;
  assign m_tdata   = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_res};

  always_comb begin
    header_state_next = header_state;
    byte_count_next   = byte_count;
    frame_flag_next   = frame_flag;
    store_en          = 1'b0;
    res_next          = '0;
    if (!s_tuser) begin
      if (raw_capture) begin
        if (byte_count >= RAW_CAPACITY) begin
          res_next.raw_full = 1'b1;
        end else begin
          res_next.raw_valid = 1'b1;
          res_next.raw_index = byte_count[6:0];
          res_next.raw_byte  = s_tdata;
          byte_count_next    = count_inc[7:0];
        end
      end else begin
        unique case (header_state)
          HUNT_A: begin
            if (s_tdata == HDR_A) begin
              header_state_next = EXPECT_B;
              byte_count_next   = '0;
              frame_flag_next   = 1'b1;
            end
          end
          EXPECT_B: begin
            if (s_tdata == HDR_B) begin
              header_state_next = EXPECT_C;
            end else begin
              header_state_next = HUNT_A;
              frame_flag_next   = 1'b0;
            end
          end
          EXPECT_C: begin
            if (s_tdata == HDR_C) begin
              header_state_next = PAYLOAD;
            end else begin
              header_state_next = HUNT_A;
              frame_flag_next   = 1'b0;
            end
          end
          PAYLOAD: begin
            if (count_inc >= PAYLOAD_BYTES) begin
              if (payload_store[0] > TEMP_MIN) begin
                res_next.temp_valid  = 1'b1;
                res_next.temperature = {1'b0, payload_store[0]} + TEMP_OFFSET;
              end
              if (payload_store[1] < WIND_LIMIT) begin
                res_next.wind_valid = 1'b1;
                res_next.wind_speed = payload_store[1][2:0];
              end
              if (s_tdata < MODE_LIMIT) begin
                res_next.mode_valid = 1'b1;
                res_next.op_mode    = s_tdata[1:0];
              end
              frame_flag_next   = 1'b0;
              header_state_next = HUNT_A;
              byte_count_next   = '0;
            end else begin
              store_en        = (byte_count < 8'd2);
              byte_count_next = count_inc[7:0];
            end
          end
          default: header_state_next = HUNT_A;
        endcase
      end
    end
    res_next.in_frame = frame_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_capture  <= 1'b0;
      header_state <= HUNT_A;
      byte_count   <= '0;
      frame_flag   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      raw_capture <= cfg_data;
      byte_count  <= '0;
    end else if (accept) begin
      header_state <= header_state_next;
      byte_count   <= byte_count_next;
      frame_flag   <= frame_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      payload_store[byte_count[0]] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      m_tvalid   <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res_next;
      end
    end else if (accept) begin
      skid_res <= res_next;
    end
  end

endmodule

// ===== rtl/core/scfr_checker.sv =====
// port-level checker for the serial command frame receiver
// bound to the top level; depends on scfr_pkg
module scfr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [scfr_pkg::OUT_DATA_W-1:0] m_tdata
);
  import scfr_pkg::*;

  result_t r;
  assign r = result_t'(m_tdata[RESULT_W-1:0]);

  // input only stalls while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("s_tready low with no pending result");

  // held result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // raw and frame results never mix in one beat
  a_mode_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !((r.raw_valid || r.raw_full) &&
                   (r.temp_valid || r.wind_valid || r.mode_valid)))
    else $error("raw and frame results in one beat");

  // a raw beat is either stored or dropped, and a frame completion closes the frame
  a_raw_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(r.raw_valid && r.raw_full) &&
                 !((r.temp_valid || r.wind_valid || r.mode_valid) && r.in_frame))
    else $error("inconsistent result flags");

endmodule

bind serial_command_frame_receiver scfr_checker u_scfr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
